FILE: design/trpc_pkg.sv
// Shared constants and types for the triangle pixel coverage test unit.
// Used by trpc_project and triangle_pixel_coverage_test_unit; no dependencies.
`timescale 1ns / 1ps

package trpc_pkg;

  // Field and register widths.
  localparam int unsigned CoordW    = 24;
  localparam int unsigned PixW      = 12;
  localparam int unsigned DimW      = 13;
  localparam int unsigned ColorW    = 32;
  localparam int unsigned IndexW    = 24;
  localparam int unsigned MaxDim    = 4096;

  // Screen coordinates are signed with 13 integer and FracBits fraction bits.
  localparam int unsigned FracBits  = 8;
  localparam int unsigned ScrW      = 13 + FracBits + 1;

  // Projection divider: one quotient bit per stage.
  localparam int unsigned DivSteps  = ScrW;
  localparam int unsigned MagW      = CoordW + 1;
  localparam int unsigned DenW      = CoordW + 1;
  localparam int unsigned ProdW     = MagW + DimW;
  localparam int unsigned DivW      = DenW + DivSteps;

  // Projection latency: sum, multiply, range check, divide steps, sign fixup.
  localparam int unsigned ProjLat   = 3 + DivSteps + 1;

  // Edge test: edge vectors, cross products, compare and output.
  localparam int unsigned EdgeW     = ScrW + 1;
  localparam int unsigned CrossW    = 2 * EdgeW + 1;
  localparam int unsigned TotalLat  = 1 + ProjLat + 3;

  // Register map, selected by paddr[2].
  localparam logic RegFrameWidth  = 1'b0;
  localparam logic RegFrameHeight = 1'b1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ScrW-1:0]   scr_t;
  typedef logic        [DimW-1:0]   dim_t;

  // Per-request sideband carried alongside the projection units.
  typedef struct packed {
    logic [PixW-1:0]   px;
    logic [PixW-1:0]   py;
    logic [ColorW-1:0] color;
    logic [IndexW-1:0] index;
    logic              invalid;
    logic              in_frame;
  } side_t;

endpackage

FILE: design/trpc_project.sv
// Pipelined perspective projection of one coordinate to screen fixed point.
// Depends on trpc_pkg; one request per cycle.
`timescale 1ns / 1ps

module trpc_project (
  input  logic            clk_i,
  input  trpc_pkg::coord_t v_i,
  input  trpc_pkg::coord_t z_i,
  input  trpc_pkg::dim_t   dim_i,
  output trpc_pkg::scr_t   scr_o
);
  import trpc_pkg::*;

  logic signed [MagW-1:0] sum_d;
  logic [MagW-1:0]  mag_q;
  logic             neg1_q;
  logic [DenW-1:0]  den1_q;
  dim_t             dim1_q;

  logic [DivW-1:0]  num2_q;
  logic             neg2_q;
  logic [DenW-1:0]  den2_q;

  logic [DivW-1:0]     rem_q [DivSteps+1];
  logic [DivSteps-1:0] quo_q [DivSteps+1];
  logic [DenW-1:0]     den_q [DivSteps+1];
  logic                neg_q [DivSteps+1];
  logic                ovf_q [DivSteps+1];

  logic [DivSteps:0]   qn_d;
  scr_t                scr_d;
  scr_t                scr_q;

  // Numerator sign and magnitude of v + z; the divisor is 2z.
  assign sum_d = MagW'(v_i) + MagW'(z_i);

  always_ff @(posedge clk_i) begin
    mag_q  <= sum_d[MagW-1] ? MagW'(-sum_d) : MagW'(sum_d);
    neg1_q <= sum_d[MagW-1];
    den1_q <= {z_i, 1'b0};
    dim1_q <= dim_i;
  end

  // Scale by the frame dimension and the fraction bits.
  always_ff @(posedge clk_i) begin
    num2_q <= DivW'({ProdW'(mag_q) * ProdW'(dim1_q), {FracBits{1'b0}}});
    neg2_q <= neg1_q;
    den2_q <= den1_q;
  end

  // Flag quotients that do not fit the divider, then start it.
  always_ff @(posedge clk_i) begin
    rem_q[0] <= num2_q;
    quo_q[0] <= '0;
    den_q[0] <= den2_q;
    neg_q[0] <= neg2_q;
    ovf_q[0] <= num2_q >= (DivW'(den2_q) << DivSteps);
  end

  // Restoring division, most significant quotient bit first.
  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [DivW-1:0]     sub_d;
    logic                take_d;
    logic [DivSteps-1:0] quo_d;

    assign sub_d  = DivW'(den_q[k]) << (DivSteps - 1 - k);
    assign take_d = rem_q[k] >= sub_d;

    // This step's quotient bit joins the bits found so far.
    always_comb begin
      quo_d = quo_q[k];
      quo_d[DivSteps-1-k] = take_d;
    end

    always_ff @(posedge clk_i) begin
      if (take_d) begin
        rem_q[k+1] <= rem_q[k] - sub_d;
      end else begin
        rem_q[k+1] <= rem_q[k];
      end
      quo_q[k+1] <= quo_d;
      den_q[k+1] <= den_q[k];
      neg_q[k+1] <= neg_q[k];
      ovf_q[k+1] <= ovf_q[k];
    end
  end

  // Floor toward minus infinity and saturate to the screen range.
  always_comb begin
    qn_d = {1'b0, quo_q[DivSteps]} + (DivSteps+1)'(rem_q[DivSteps] != '0);
    if (!neg_q[DivSteps]) begin
      if (ovf_q[DivSteps] || quo_q[DivSteps][DivSteps-1]) begin
        scr_d = {1'b0, {(ScrW-1){1'b1}}};
      end else begin
        scr_d = scr_t'(quo_q[DivSteps]);
      end
    end else begin
      if (ovf_q[DivSteps] || qn_d > ((DivSteps+1)'(1) << (ScrW-1))) begin
        scr_d = {1'b1, {(ScrW-1){1'b0}}};
      end else begin
        scr_d = scr_t'(-qn_d);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scr_q <= scr_d;
  end

  assign scr_o = scr_q;

endmodule

FILE: design/triangle_pixel_coverage_test_unit.sv
// Top level of the triangle pixel coverage test: APB registers, input stage,
// a trpc_project unit per vertex x and y coordinate, sideband line and the edge test on every edge. Uses trpc_pkg.
`timescale 1ns / 1ps

// Channel    | Direction | Handshake                         | Payload
// request    | in        | start high, busy low              | vertices, pixel, fill_color
// result     | out       | result_valid_o for one cycle      | covered, index, color, invalid
// config     | in/out    | psel, penable, pwrite, pready     | frame_width, frame_height
//
// One request is taken every cycle; busy is never raised.
// The pipeline depth from an accepted request to its result is set by the
// 22-step bit-per-stage divider inside each projection unit.
// Reset clears the valid bits and sets the frame to 640 by 480; no clearing pass.
// The receiver cannot stall, so nothing in the pipeline ever holds.

module triangle_pixel_coverage_test_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  trpc_pkg::coord_t          vertex_a_x_i,
  input  trpc_pkg::coord_t          vertex_a_y_i,
  input  trpc_pkg::coord_t          vertex_a_z_i,
  input  trpc_pkg::coord_t          vertex_b_x_i,
  input  trpc_pkg::coord_t          vertex_b_y_i,
  input  trpc_pkg::coord_t          vertex_b_z_i,
  input  trpc_pkg::coord_t          vertex_c_x_i,
  input  trpc_pkg::coord_t          vertex_c_y_i,
  input  trpc_pkg::coord_t          vertex_c_z_i,
  input  logic [trpc_pkg::PixW-1:0] pixel_x_i,
  input  logic [trpc_pkg::PixW-1:0] pixel_y_i,
  input  logic [trpc_pkg::ColorW-1:0] fill_color_i,
  output logic                      result_valid_o,
  output logic                      covered_o,
  output logic [trpc_pkg::IndexW-1:0] pixel_index_o,
  output logic [trpc_pkg::ColorW-1:0] write_color_o,
  output logic                      invalid_triangle_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import trpc_pkg::*;

  dim_t   frame_width_q, frame_height_q;
  dim_t   w_clamp, h_clamp;
  logic   cfg_we;

  logic   s0_vld_q;
  coord_t vx_q [3];
  coord_t vy_q [3];
  coord_t vz_q [3];
  logic [PixW-1:0]   px_q, py_q;
  logic [ColorW-1:0] color_q;
  dim_t   w_q, h_q;

  side_t  side_d;
  side_t  side_q [ProjLat];
  logic   vld_q  [ProjLat];

  scr_t   sx [3];
  scr_t   sy [3];
  logic [PixW+FracBits-1:0] cx, cy;

  logic signed [EdgeW-1:0] ex_q [3], ey_q [3], ax_q [3], ay_q [3];
  logic   tl1_q [3];
  side_t  e1_side_q;
  logic   e1_vld_q;

  logic signed [2*EdgeW-1:0] p1_q [3], p2_q [3];
  logic   tl2_q [3];
  side_t  e2_side_q;
  logic   e2_vld_q;

  logic   pass_d [3];
  logic   cov_d;

  // Configuration registers.
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= dim_t'(640);
      frame_height_q <= dim_t'(480);
    end else if (cfg_we) begin
      case (paddr[2])
        RegFrameWidth:  frame_width_q  <= pwdata[DimW-1:0];
        RegFrameHeight: frame_height_q <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegFrameWidth:  prdata = 32'(frame_width_q);
      RegFrameHeight: prdata = 32'(frame_height_q);
      default:        prdata = '0;
    endcase
  end

  assign w_clamp = (frame_width_q  > dim_t'(MaxDim)) ? dim_t'(MaxDim) : frame_width_q;
  assign h_clamp = (frame_height_q > dim_t'(MaxDim)) ? dim_t'(MaxDim) : frame_height_q;

  // Input stage: a request is taken every cycle.
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    vx_q[0] <= vertex_a_x_i; vy_q[0] <= vertex_a_y_i; vz_q[0] <= vertex_a_z_i;
    vx_q[1] <= vertex_b_x_i; vy_q[1] <= vertex_b_y_i; vz_q[1] <= vertex_b_z_i;
    vx_q[2] <= vertex_c_x_i; vy_q[2] <= vertex_c_y_i; vz_q[2] <= vertex_c_z_i;
    px_q    <= pixel_x_i;
    py_q    <= pixel_y_i;
    color_q <= fill_color_i;
    w_q     <= w_clamp;
    h_q     <= h_clamp;
  end

  // Projection units, one per vertex x and y coordinate.
  for (genvar i = 0; i < 3; i++) begin : g_vtx
    trpc_project u_proj_x (.clk_i, .v_i(vx_q[i]), .z_i(vz_q[i]), .dim_i(w_q), .scr_o(sx[i]));
    trpc_project u_proj_y (.clk_i, .v_i(vy_q[i]), .z_i(vz_q[i]), .dim_i(h_q), .scr_o(sy[i]));
  end

  // Sideband: validity, frame bounds and linear index, delayed to match.
  always_comb begin
    side_d.px       = px_q;
    side_d.py       = py_q;
    side_d.color    = color_q;
    side_d.index    = IndexW'(py_q * w_q + (PixW+DimW)'(px_q));
    side_d.invalid  = (vz_q[0] <= 0) || (vz_q[1] <= 0) || (vz_q[2] <= 0);
    side_d.in_frame = (DimW'(px_q) < w_q) && (DimW'(py_q) < h_q);
  end

  for (genvar s = 0; s < ProjLat; s++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= (s == 0) ? s0_vld_q : vld_q[(s == 0) ? 0 : s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      side_q[s] <= (s == 0) ? side_d : side_q[(s == 0) ? 0 : s-1];
    end
  end

  // Edge vectors, centre offsets and top-left flags.
  assign cx = {side_q[ProjLat-1].px, 1'b1, {(FracBits-1){1'b0}}};
  assign cy = {side_q[ProjLat-1].py, 1'b1, {(FracBits-1){1'b0}}};

  for (genvar i = 0; i < 3; i++) begin : g_edge
    localparam int unsigned J = (i + 1) % 3;
    logic signed [EdgeW-1:0] ex_d, ey_d;
    logic signed [CrossW-1:0] cr_d;

    assign ex_d = EdgeW'(sx[J]) - EdgeW'(sx[i]);
    assign ey_d = EdgeW'(sy[J]) - EdgeW'(sy[i]);

    always_ff @(posedge clk_i) begin
      ex_q[i]  <= ex_d;
      ey_q[i]  <= ey_d;
      ax_q[i]  <= $signed(EdgeW'(cx)) - EdgeW'(sx[i]);
      ay_q[i]  <= $signed(EdgeW'(cy)) - EdgeW'(sy[i]);
      tl1_q[i] <= (ex_d >= 0 && ey_d > 0) || (ex_d > 0 && ey_d == 0);
    end

    // Cross product terms.
    always_ff @(posedge clk_i) begin
      p1_q[i]  <= ax_q[i] * ey_q[i];
      p2_q[i]  <= ay_q[i] * ex_q[i];
      tl2_q[i] <= tl1_q[i];
    end

    // Edge passes when the cross product is positive, or zero on a top-left edge.
    assign cr_d      = CrossW'(p1_q[i]) - CrossW'(p2_q[i]);
    assign pass_d[i] = (cr_d > 0) || (cr_d == 0 && tl2_q[i]);
  end

  always_ff @(posedge clk_i) begin
    e1_side_q <= side_q[ProjLat-1];
    e2_side_q <= e1_side_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_vld_q       <= 1'b0;
      e2_vld_q       <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      e1_vld_q       <= vld_q[ProjLat-1];
      e2_vld_q       <= e1_vld_q;
      result_valid_o <= e2_vld_q;
    end
  end

  // Output registers.
  assign cov_d = pass_d[0] && pass_d[1] && pass_d[2]
              && !e2_side_q.invalid && e2_side_q.in_frame;

  always_ff @(posedge clk_i) begin
    covered_o          <= cov_d;
    pixel_index_o      <= e2_side_q.index;
    write_color_o      <= cov_d ? e2_side_q.color : '0;
    invalid_triangle_o <= e2_side_q.invalid;
  end

  // A covered pixel never belongs to an invalid triangle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && covered_o |-> !invalid_triangle_o)
    else $error("covered pixel reported for an invalid triangle");

  // A colour is written only for a covered pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (write_color_o != '0) |-> covered_o)
    else $error("write color without coverage");

  // A width write lands in the register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we && paddr[2] == RegFrameWidth |=> frame_width_q == $past(pwdata[DimW-1:0]))
    else $error("frame width write lost");

endmodule

FILE: test/tb_triangle_pixel_coverage_test_unit.sv
// Testbench for triangle_pixel_coverage_test_unit: random and directed coverage requests
// are checked against a fixed-point edge-function predictor. Depends on trpc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_triangle_pixel_coverage_test_unit;
  import trpc_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;

  typedef struct {
    logic        covered;
    logic [23:0] index;
    logic [31:0] color;
    logic        invalid;
  } pixel_result_t;

  // Queue of predicted coverage results; each accepted request pushes one entry.
  class coverage_board;
    pixel_result_t pending[$];
    int unsigned   mismatches;
    int unsigned   checked;

    function void note_request(pixel_result_t r);
      pending.push_back(r);
    endfunction

    function void check_result(logic cov, logic [23:0] idx, logic [31:0] col, logic inv);
      pixel_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with no request pending, index %0d", idx);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.covered !== cov || e.index !== idx || e.color !== col || e.invalid !== inv) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected cov=%b idx=%0d col=%h inv=%b, got cov=%b idx=%0d col=%h inv=%b",
                   e.covered, e.index, e.color, e.invalid, cov, idx, col, inv);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t vtx_i [9];
  logic [PixW-1:0] pixel_x_i = '0;
  logic [PixW-1:0] pixel_y_i = '0;
  logic [ColorW-1:0] fill_color_i = '0;
  logic result_valid_o, covered_o, invalid_triangle_o;
  logic [IndexW-1:0] pixel_index_o;
  logic [ColorW-1:0] write_color_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Predictor copy of the frame registers.
  logic [12:0] cur_width = 13'd640;
  logic [12:0] cur_height = 13'd480;

  coverage_board board;
  int unsigned requests_sent;
  int unsigned idle_count = 0;
  bit          no_idle;

  triangle_pixel_coverage_test_unit u_dut (
    .clk_i, .rst_ni, .start, .busy,
    .vertex_a_x_i(vtx_i[0]), .vertex_a_y_i(vtx_i[1]), .vertex_a_z_i(vtx_i[2]),
    .vertex_b_x_i(vtx_i[3]), .vertex_b_y_i(vtx_i[4]), .vertex_b_z_i(vtx_i[5]),
    .vertex_c_x_i(vtx_i[6]), .vertex_c_y_i(vtx_i[7]), .vertex_c_z_i(vtx_i[8]),
    .pixel_x_i, .pixel_y_i, .fill_color_i,
    .result_valid_o, .covered_o, .pixel_index_o, .write_color_o, .invalid_triangle_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Project one camera coordinate onto the screen, floor division then saturation.
  function automatic longint project_coord(longint v, longint z, longint dim);
    longint num, den, q, lim;
    num = (v + z) * dim * (64'sd1 <<< FracBits);
    den = 2 * z;
    q = num / den;
    lim = 64'sd1 <<< (13 + FracBits);
    if (num % den != 0 && num < 0) q -= 1;
    if (q > lim - 1) q = lim - 1;
    if (q < -lim) q = -lim;
    return q;
  endfunction

  function automatic bit edge_inside(longint px, longint py, longint sx, longint sy,
                                     longint ex, longint ey);
    longint c;
    bit tl;
    c = (px - sx) * ey - (py - sy) * ex;
    tl = (ex >= 0 && ey > 0) || (ex > 0 && ey == 0);
    return c > 0 || (c == 0 && tl);
  endfunction

  // Expected result for one coverage request under the current frame size.
  function automatic pixel_result_t predict_coverage(
      coord_t v[9], logic [11:0] px, logic [11:0] py, logic [31:0] col);
    pixel_result_t r;
    longint w, h, cx, cy;
    longint sx[3], sy[3];
    bit inv, cov;
    w = (cur_width > MaxDim) ? MaxDim : cur_width;
    h = (cur_height > MaxDim) ? MaxDim : cur_height;
    inv = 0;
    cov = 0;
    for (int k = 0; k < 3; k++) if (v[3*k+2] <= 0) inv = 1;
    if (!inv && px < w && py < h) begin
      for (int k = 0; k < 3; k++) begin
        sx[k] = project_coord(v[3*k], v[3*k+2], w);
        sy[k] = project_coord(v[3*k+1], v[3*k+2], h);
      end
      cx = px * (64'sd1 <<< FracBits) + (64'sd1 <<< (FracBits - 1));
      cy = py * (64'sd1 <<< FracBits) + (64'sd1 <<< (FracBits - 1));
      cov = edge_inside(cx, cy, sx[0], sy[0], sx[1] - sx[0], sy[1] - sy[0])
         && edge_inside(cx, cy, sx[1], sy[1], sx[2] - sx[1], sy[2] - sy[1])
         && edge_inside(cx, cy, sx[2], sy[2], sx[0] - sx[2], sy[0] - sy[2]);
    end
    r.covered = cov;
    r.index = 24'(longint'(py) * w + longint'(px));
    r.color = cov ? col : '0;
    r.invalid = inv;
    return r;
  endfunction

  // Random idle burst before a request, unless the tail of the run is reached.
  task automatic maybe_idle();
    int unsigned n;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Issue one coverage request and wait for it to be accepted.
  task automatic send_request(coord_t v[9], logic [11:0] px, logic [11:0] py,
                              logic [31:0] col);
    maybe_idle();
    foreach (v[k]) vtx_i[k] <= v[k];
    pixel_x_i <= px;
    pixel_y_i <= py;
    fill_color_i <= col;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    board.note_request(predict_coverage(v, px, py, col));
    requests_sent++;
  endtask

  // Wait for all results, then write a frame register over APB.
  task automatic write_frame_reg(logic sel, logic [12:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= {19'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == RegFrameWidth) cur_width = value;
    else cur_height = value;
  endtask

  // Random triangle, mostly with valid depths and centered near the frame.
  task automatic random_request();
    coord_t v[9];
    logic [11:0] px, py;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      if (k % 3 == 2)
        v[k] = (kind == 0) ? coord_t'($urandom) : coord_t'($urandom_range(1, 24'h7fffff));
      else if (kind < 6)
        v[k] = coord_t'($signed($urandom_range(0, 24'h3ffff)) - 32'sh1ffff);
      else
        v[k] = coord_t'($urandom);
    end
    if (kind >= 2 && kind < 6) begin
      v[2] = 24'h10000;
      v[5] = 24'h10000;
      v[8] = 24'h10000;
    end
    if ($urandom_range(0, 4) == 0) begin
      px = 12'($urandom);
      py = 12'($urandom);
    end else begin
      px = 12'($urandom_range(0, (cur_width > 0) ? cur_width - 1 : 0));
      py = 12'($urandom_range(0, (cur_height > 0) ? cur_height - 1 : 0));
    end
    send_request(v, px, py, $urandom);
  endtask

  // Result monitor and watchdog on idle cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o)
        board.check_result(covered_o, pixel_index_o, write_color_o, invalid_triangle_o);
      if (result_valid_o || (start && !busy)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    coord_t v[9];
    logic [12:0] widths[4];
    logic [12:0] heights[4];
    foreach (vtx_i[k]) vtx_i[k] = '0;
    board = new();
    no_idle = 0;
    widths = '{13'd640, 13'd1, 13'd8191, 13'd37};
    heights = '{13'd480, 13'd4096, 13'd0, 13'd29};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: large covering triangle, its center, corners and extremes.
    v = '{-24'sh20000, -24'sh20000, 24'sh10000, 24'sh20000, -24'sh20000, 24'sh10000,
          24'sh0, 24'sh20000, 24'sh10000};
    send_request(v, 12'd320, 12'd240, 32'hdeadbeef);
    send_request(v, 12'd0, 12'd0, 32'hffffffff);
    send_request(v, 12'd639, 12'd479, 32'h00000000);
    send_request(v, 12'd640, 12'd0, 32'h12345678);
    send_request(v, 12'd0, 12'd480, 32'h12345678);
    send_request(v, 12'hfff, 12'hfff, 32'ha5a5a5a5);
    // Second triangle, same winding: one pixel just inside a corner and one just outside it.
    v = '{24'sh0, 24'sh0, 24'sh10000, -24'sh10000, 24'sh0, 24'sh10000,
          24'sh0, -24'sh10000, 24'sh10000};
    send_request(v, 12'd319, 12'd239, 32'h5a5a5a5a);
    send_request(v, 12'd320, 12'd240, 32'h5a5a5a5a);
    // Zero and negative depths flag the triangle invalid; extreme values follow.
    v[2] = 24'sh0;
    send_request(v, 12'd10, 12'd10, 32'h1);
    v[2] = 24'sh800000;
    send_request(v, 12'd10, 12'd10, 32'h2);
    v = '{24'sh7fffff, 24'sh800000, 24'sh1, 24'sh800000, 24'sh7fffff, 24'sh1,
          24'sh7fffff, 24'sh7fffff, 24'sh7fffff};
    send_request(v, 12'd5, 12'd5, 32'h3);
    send_request(v, 12'd0, 12'd479, 32'h4);

    // Random requests across several frame settings, extremes included.
    for (int phase = 0; phase < 4; phase++) begin
      write_frame_reg(RegFrameWidth, widths[phase]);
      write_frame_reg(RegFrameHeight, heights[phase]);
      for (int n = 0; n < 125; n++) begin
        if (phase == 3 && n >= 60) no_idle = 1;
        random_request();
      end
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (TotalLat + 5) @(posedge clk_i);
    $display("Sent %0d coverage requests over four frame sizes; %0d results checked.",
             requests_sent, board.checked);
    if (board.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
